// ----- rtl/rst_pkg.sv -----
// Package for the request state table: types, codes and defaults.
package rst_pkg;

    localparam int SLOTS_DEF    = 1024;
    localparam int KEY_BITS_DEF = 64;
    localparam int LIMIT_W      = 10;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 10'd716;

    // operations
    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_SET    = 2'd1;
    localparam logic [1:0] OP_RESET  = 2'd2;

    // request states
    localparam logic [1:0] ST_NONE = 2'd0;
    localparam logic [1:0] ST_BUSY = 2'd1;
    localparam logic [1:0] ST_OK   = 2'd2;
    localparam logic [1:0] ST_FAIL = 2'd3;

    // error codes
    localparam logic [2:0] E_NONE      = 3'd0;
    localparam logic [2:0] E_UNSTARTED = 3'd1;
    localparam logic [2:0] E_NOBIND    = 3'd2;
    localparam logic [2:0] E_DONE_CHG  = 3'd3;
    localparam logic [2:0] E_FAIL_CHG  = 3'd4;
    localparam logic [2:0] E_NOT_BUSY  = 3'd5;
    localparam logic [2:0] E_UNKNOWN   = 3'd6;
    localparam logic [2:0] E_FULL      = 3'd7;

    typedef struct packed {
        logic [1:0]  op;
        logic [63:0] key;
        logic [1:0]  state_in;
        logic [31:0] binding_in;
        logic        binding_given;
    } t_req;

    typedef struct packed {
        logic [1:0]  state_out;
        logic [31:0] binding_out;
        logic        binding_valid;
        logic [2:0]  error;
    } t_rsp;

    // outcome of one request: writes to make and the result to report
    typedef struct packed {
        logic        upd;
        logic        ins;
        logic [1:0]  st;
        logic [32:0] bnd;
        t_rsp        rsp;
    } t_dec;

endpackage

// ----- rtl/rst_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module rst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/rst_rules.sv -----
// Transition rules: decides the error, the entry writes and the reported result.
module rst_rules
    import rst_pkg::*;
(
    input  t_req        i_req,
    input  logic        i_found,
    input  logic        i_full,
    input  logic [1:0]  i_cur_st,
    input  logic [32:0] i_cur_bnd,
    output t_dec        o_dec
);

    logic [32:0] nb;
    logic [1:0]  rep_st;
    logic [32:0] rep_bnd;
    logic [2:0]  err;
    logic        upd;
    logic        ins;
    logic [1:0]  new_st;
    logic [32:0] new_bnd;

    assign nb = (i_req.state_in == ST_OK) ? {1'b1, i_req.binding_in} : 33'd0;

    always_comb begin
        err     = E_NONE;
        upd     = 1'b0;
        ins     = 1'b0;
        new_st  = i_req.state_in;
        new_bnd = nb;
        rep_st  = i_found ? i_cur_st : ST_NONE;
        rep_bnd = i_found ? i_cur_bnd : 33'd0;
        case (i_req.op)
            OP_SET: begin
                if (i_req.state_in == ST_NONE) begin
                    err = E_UNSTARTED;
                end else if (i_req.state_in == ST_OK && !i_req.binding_given) begin
                    err = E_NOBIND;
                end else if (i_found) begin
                    if (i_cur_st == ST_OK) begin
                        err = (i_req.state_in == ST_OK && i_cur_bnd == nb) ? E_NONE
                                                                            : E_DONE_CHG;
                    end else if (i_cur_st == ST_FAIL) begin
                        err = (i_req.state_in == ST_FAIL) ? E_NONE : E_FAIL_CHG;
                    end else if (!(i_cur_st == ST_BUSY && i_req.state_in == ST_BUSY)) begin
                        upd     = 1'b1;
                        rep_st  = new_st;
                        rep_bnd = new_bnd;
                    end
                end else if (i_full) begin
                    err = E_FULL;
                end else begin
                    ins     = 1'b1;
                    rep_st  = new_st;
                    rep_bnd = new_bnd;
                end
            end
            OP_RESET: begin
                new_st  = ST_NONE;
                new_bnd = 33'd0;
                if (!i_found) begin
                    err = E_UNKNOWN;
                end else if (i_cur_st != ST_BUSY) begin
                    err = E_NOT_BUSY;
                end else begin
                    upd     = 1'b1;
                    rep_st  = ST_NONE;
                    rep_bnd = 33'd0;
                end
            end
            default: begin
                // lookup, and the unused code, report only
            end
        endcase
    end

    always_comb begin
        o_dec                   = '0;
        o_dec.upd               = upd;
        o_dec.ins               = ins;
        o_dec.st                = new_st;
        o_dec.bnd               = new_bnd;
        o_dec.rsp.state_out     = rep_st;
        o_dec.rsp.binding_valid = rep_bnd[32];
        o_dec.rsp.binding_out   = rep_bnd[32] ? rep_bnd[31:0] : 32'd0;
        o_dec.rsp.error         = err;
    end

endmodule

// ----- rtl/request_state_table.sv -----
// Top level of the request state table: probe sequencer, slot and entry memories.
//
// Usage
//   A request (op, key, state_in, binding_in, binding_given) is taken on a rising
//   edge with start high and busy low. Ops: lookup, set (monotonic transition
//   rules) and reset of an in-progress entry.
//   Each request gives exactly one result on o_rsp, marked by o_done high for one
//   cycle. The receiver cannot stall; results are never held back.
//   entry_limit is written through i_cfg_we / i_cfg_wdata; the user writes it only while idle, unchecked by the block.
// Probing
//   Linear probing over the slot memory: each probed slot costs one slot read
//   and, when occupied, one entry read.
//   o_done is registered from the decision: on an empty slot in the slot state,
//   or on a key match in the entry state; a mismatch probes the next slot.
//   busy falls as o_done rises; the next request is taken at the following edge.
// Reset
//   i_rst_n (synchronous, active low) clears the count and restores entry_limit
//   to 716, then a clearing pass writes every slot to empty, one slot a cycle,
//   with busy high. Entry memory is not cleared.
module request_state_table
    import rst_pkg::*;
#(
    parameter int SLOTS    = SLOTS_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  t_req               i_req,
    input  logic               i_cfg_we,
    input  logic [LIMIT_W-1:0] i_cfg_wdata,
    output logic               o_done,
    output t_rsp               o_rsp
);

    localparam int SW  = $clog2(SLOTS);
    localparam int CW  = (SW > LIMIT_W) ? SW : LIMIT_W;
    localparam int EWD = KEY_BITS + 35;
    localparam int NCH = (KEY_BITS + SW - 1) / SW;

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_SLOT  = 2'd2;
    localparam logic [1:0] S_ENTRY = 2'd3;

    logic [1:0]          r_state, n_state;
    logic [SW-1:0]       r_clr;
    logic [SW-1:0]       r_count;
    logic [LIMIT_W-1:0]  r_limit;
    logic                r_done;
    t_rsp                r_rsp;
    t_req                r_req;
    logic [KEY_BITS-1:0] r_key;
    logic [SW-1:0]       r_slot;
    logic [SW-1:0]       r_eidx;

    logic [KEY_BITS-1:0] in_key;
    logic [SW-1:0]       hash;
    logic                accept;

    logic                slot_we;
    logic [SW-1:0]       slot_waddr, slot_wdata, slot_raddr, slot_rdata;
    logic                ent_we;
    logic [SW-1:0]       ent_waddr, ent_raddr;
    logic [EWD-1:0]      ent_wdata, ent_rdata;

    logic [KEY_BITS-1:0] ent_key;
    logic [32:0]         ent_bnd;
    logic [1:0]          ent_st;
    logic                slot_empty, key_hit, decide, found, full;
    t_dec                dec;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;
    assign in_key = i_req.key[KEY_BITS-1:0];

    // home slot: XOR fold of the key in slot-index sized chunks
    always_comb begin
        hash = '0;
        for (int i = 0; i < NCH; i++) begin
            hash = hash ^ SW'(in_key >> (i * SW));
        end
    end

    assign ent_key = ent_rdata[EWD-1:35];
    assign ent_bnd = ent_rdata[34:2];
    assign ent_st  = ent_rdata[1:0];

    assign slot_empty = (slot_rdata == '0);
    assign key_hit    = (ent_key == r_key);
    assign found      = (r_state == S_ENTRY);
    assign decide     = (r_state == S_SLOT && slot_empty) || (r_state == S_ENTRY && key_hit);
    assign full       = (CW'(r_count) >= CW'(r_limit)) || (&r_count);

    rst_rules u_rules (
        .i_req     (r_req),
        .i_found   (found),
        .i_full    (full),
        .i_cur_st  (ent_st),
        .i_cur_bnd (ent_bnd),
        .o_dec     (dec)
    );

    // slot memory: entry number plus one, zero for an empty slot
    assign slot_raddr = (r_state == S_IDLE) ? hash : r_slot + 1'b1;
    assign slot_we    = (r_state == S_CLEAR) || (decide && dec.ins);
    assign slot_waddr = (r_state == S_CLEAR) ? r_clr : r_slot;
    assign slot_wdata = (r_state == S_CLEAR) ? '0 : r_count + 1'b1;

    rst_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (slot_we),
        .i_waddr (slot_waddr),
        .i_wdata (slot_wdata),
        .i_raddr (slot_raddr),
        .o_rdata (slot_rdata)
    );

    // entry memory: {key, binding valid + binding, state}
    assign ent_raddr = slot_rdata - 1'b1;
    assign ent_we    = decide && (dec.upd || dec.ins);
    assign ent_waddr = dec.ins ? r_count : r_eidx;
    assign ent_wdata = {(dec.ins ? r_key : ent_key), dec.bnd, dec.st};

    rst_ram #(.WIDTH(EWD), .DEPTH(SLOTS)) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr (ent_waddr),
        .i_wdata (ent_wdata),
        .i_raddr (ent_raddr),
        .o_rdata (ent_rdata)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (&r_clr) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (accept) n_state = S_SLOT;
            end
            S_SLOT: begin
                n_state = slot_empty ? S_IDLE : S_ENTRY;
            end
            S_ENTRY: begin
                n_state = key_hit ? S_IDLE : S_SLOT;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_count <= '0;
            r_limit <= LIMIT_RESET;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= decide;
            if (r_state == S_CLEAR) r_clr <= r_clr + 1'b1;
            if (decide && dec.ins) r_count <= r_count + 1'b1;
            if (i_cfg_we) r_limit <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req  <= i_req;
            r_key  <= in_key;
            r_slot <= hash;
        end
        if (r_state == S_SLOT) r_eidx <= ent_raddr;
        if (r_state == S_ENTRY && !key_hit) r_slot <= r_slot + 1'b1;
        if (decide) r_rsp <= dec.rsp;
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

`ifndef NO_ASSERTIONS
    // a result always follows a cycle of work
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && o_done) |-> $past(busy))
        else $error("result strobe without a request in progress");

    // a new slot is only claimed where the probe found it empty
    a_insert_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (slot_we && r_state != S_CLEAR) |-> slot_empty)
        else $error("insert overwrote an occupied slot");

    // the entry count grows by at most one per cycle
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_count == $past(r_count) ||
                            r_count == $past(r_count) + 1'b1))
        else $error("entry count jumped");

    // no result in the cycle straight after a request is taken
    a_no_early_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_done)
        else $error("result strobed too early");
`endif

endmodule
